// ===== src/tsg3_pkg.sv =====
// Package: shared types, symbol codes and constants for the turtle segment generator.
`default_nettype none
package tsg3_pkg;

   localparam int StackDepth = 32;
   localparam int LevelWidth = $clog2(StackDepth + 1);
   localparam int AddrWidth  = (StackDepth > 1) ? $clog2(StackDepth) : 1;
   localparam int QueueDepth = 2;

   localparam logic signed [15:0] OneQ14 = 16'sd16384;

   localparam logic [7:0] SymForward  = 8'h46; // F
   localparam logic [7:0] SymPitchUp  = 8'h5e; // ^
   localparam logic [7:0] SymPitchDn  = 8'h76; // v
   localparam logic [7:0] SymYawL     = 8'h3e; // >
   localparam logic [7:0] SymYawR     = 8'h3c; // <
   localparam logic [7:0] SymRollP    = 8'h2b; // +
   localparam logic [7:0] SymRollM    = 8'h2d; // -
   localparam logic [7:0] SymPush     = 8'h5b; // [
   localparam logic [7:0] SymPop      = 8'h5d; // ]

   localparam logic [1:0] CsrCos  = 2'd0;
   localparam logic [1:0] CsrSin  = 2'd1;
   localparam logic [1:0] CsrStep = 2'd2;

   localparam logic [1:0] StatusSegment   = 2'd0;
   localparam logic [1:0] StatusOverflow  = 2'd1;
   localparam logic [1:0] StatusUnderflow = 2'd2;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_FORWARD,
      OP_ROTATE,
      OP_PUSH,
      OP_POP
   } op_type;

   // Which row pair a rotation mixes: (r0, r1) -> (c r0 + s r1, -s r0 + c r1)
   typedef enum logic [1:0] {
      AXIS_Z,   // rows 0,1
      AXIS_Y,   // rows 2,0
      AXIS_X    // rows 1,2
   } axis_type;

   typedef struct packed {
      op_type   op;
      axis_type axis;
      logic     negate;
      logic     home;
   } cmd_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic signed [31:0] start_z;
      logic signed [31:0] end_x;
      logic signed [31:0] end_y;
      logic signed [31:0] end_z;
   } result_type;

   function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
      logic signed [33:0] hi;
      logic signed [33:0] lo;
      hi = 34'sd32767;
      lo = -34'sd32768;
      if (v > hi) return 16'sh7fff;
      else if (v < lo) return 16'sh8000;
      else return v[15:0];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
      if (v[32] != v[31]) return v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      else return v[31:0];
   endfunction

endpackage
`default_nettype wire

// ===== src/tsg3_if.sv =====
// Interfaces: valid/ready channels for symbols, results and register writes.
`default_nettype none
interface tsg3_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] symbol;
   logic       new_string;
   modport source (output valid, output symbol, output new_string, input ready);
   modport sink (input valid, input symbol, input new_string, output ready);
endinterface

interface tsg3_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic signed [31:0] start_x;
   logic signed [31:0] start_y;
   logic signed [31:0] start_z;
   logic signed [31:0] end_x;
   logic signed [31:0] end_y;
   logic signed [31:0] end_z;
   modport source (output valid, output status, output start_x, output start_y,
      output start_z, output end_x, output end_y, output end_z, input ready);
   modport sink (input valid, input status, input start_x, input start_y,
      input start_z, input end_x, input end_y, input end_z, output ready);
endinterface

interface tsg3_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [23:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== src/turtle_segment_generator_3d_top.sv =====
// Top level: 3-D L-system turtle that turns symbols into line segments.
// Channels: req (symbol, new_string) in, rsp (status + segment) out,
// csr register writes (index 0 cos, 1 sin, 2 step length) always ready.
// The front end decodes each symbol into a two-entry command queue; the back
// end executes each command in a first step, which registers the products
// of the rotation multipliers (or forward deltas) and reads the stack row,
// and a commit step that commits the turtle state and loads the result register.
// A command runs to its commit before the next one starts; rsp valid rises
// from the result register for 'F' and for stack overflow/underflow reports.
// 'F' yields a segment; '[' at full stack and ']' at empty stack yield a
// status-only transaction with zero coordinates; other symbols yield none.
// The stack is a 32-row memory of position+matrix, no clearing pass.
// Reset (synchronous): turtle at origin, identity heading, empty stack,
// registers at cos=1.0, sin=0, step=1.0, queue and result register empty.
// A stalled rsp holds its transaction; the back end then stops at the
// commit step, the queue fills and req.ready drops after two symbols.
// Register writes are meant for idle periods only.
`default_nettype none
module turtle_segment_generator_3d_top (
   input  wire logic   clock,
   input  wire logic   reset,
   tsg3_req_if.sink    req,
   tsg3_rsp_if.source  rsp,
   tsg3_csr_if.sink    csr
);
   tsg3_pkg::cmd_type   cmd;
   logic                cmd_valid;
   logic                cmd_take;
   logic signed [15:0]  cos_ff;
   logic signed [15:0]  sin_ff;
   logic [23:0]         step_ff;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cos_ff  <= tsg3_pkg::OneQ14;
         sin_ff  <= 16'sd0;
         step_ff <= 24'd65536;
      end else if (csr.valid) begin
         case (csr.index)
            tsg3_pkg::CsrCos:  cos_ff  <= csr.data[15:0];
            tsg3_pkg::CsrSin:  sin_ff  <= csr.data[15:0];
            tsg3_pkg::CsrStep: step_ff <= csr.data;
            default: ;
         endcase
      end
   end

   tsg3_decode u_decode (
      .clock(clock), .reset(reset), .req(req),
      .cmd(cmd), .cmd_valid(cmd_valid), .cmd_take(cmd_take)
   );

   tsg3_execute u_execute (
      .clock(clock), .reset(reset), .cmd(cmd), .cmd_valid(cmd_valid),
      .cmd_take(cmd_take), .cos_angle(cos_ff), .sin_angle(sin_ff),
      .step_length(step_ff), .rsp(rsp)
   );
endmodule
`default_nettype wire

// ===== src/tsg3_decode.sv =====
// Front end: classifies symbols and queues decoded commands.
`default_nettype none
module tsg3_decode (
   input  wire logic           clock,
   input  wire logic           reset,
   tsg3_req_if.sink            req,
   output tsg3_pkg::cmd_type   cmd,
   output logic                cmd_valid,
   input  wire logic           cmd_take
);
   tsg3_pkg::cmd_type cmd_in;
   tsg3_pkg::cmd_type queue_ff [tsg3_pkg::QueueDepth];
   logic [1:0] count_ff, count_in;
   logic       push;

   always_comb begin
      cmd_in.op = tsg3_pkg::OP_NOP;
      cmd_in.axis = tsg3_pkg::AXIS_Z;
      cmd_in.negate = 1'b0;
      cmd_in.home = req.new_string;
      case (req.symbol)
         tsg3_pkg::SymForward: cmd_in.op = tsg3_pkg::OP_FORWARD;
         tsg3_pkg::SymPitchUp: cmd_in.op = tsg3_pkg::OP_ROTATE;
         tsg3_pkg::SymPitchDn: begin
            cmd_in.op = tsg3_pkg::OP_ROTATE; cmd_in.negate = 1'b1;
         end
         tsg3_pkg::SymYawL: begin
            cmd_in.op = tsg3_pkg::OP_ROTATE; cmd_in.axis = tsg3_pkg::AXIS_Y;
         end
         tsg3_pkg::SymYawR: begin
            cmd_in.op = tsg3_pkg::OP_ROTATE; cmd_in.axis = tsg3_pkg::AXIS_Y;
            cmd_in.negate = 1'b1;
         end
         tsg3_pkg::SymRollP: begin
            cmd_in.op = tsg3_pkg::OP_ROTATE; cmd_in.axis = tsg3_pkg::AXIS_X;
         end
         tsg3_pkg::SymRollM: begin
            cmd_in.op = tsg3_pkg::OP_ROTATE; cmd_in.axis = tsg3_pkg::AXIS_X;
            cmd_in.negate = 1'b1;
         end
         tsg3_pkg::SymPush: cmd_in.op = tsg3_pkg::OP_PUSH;
         tsg3_pkg::SymPop:  cmd_in.op = tsg3_pkg::OP_POP;
         default: cmd_in.op = tsg3_pkg::OP_NOP;
      endcase
   end

   assign req.ready = (count_ff != 2'd2);
   assign push = req.valid && req.ready;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd = queue_ff[0];

   always_comb begin
      count_in = count_ff;
      if (push && !(cmd_take && cmd_valid)) count_in = count_ff + 2'd1;
      else if (!push && cmd_take && cmd_valid) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) count_ff <= 2'd0;
      else count_ff <= count_in;
   end

   always_ff @(posedge clock) begin
      if (cmd_take && cmd_valid) begin
         queue_ff[0] <= queue_ff[1];
         if (push) begin
            if (count_ff == 2'd2) queue_ff[1] <= cmd_in;
            else queue_ff[0] <= cmd_in;
         end
      end else if (push) begin
         if (count_ff == 2'd0) queue_ff[0] <= cmd_in;
         else queue_ff[1] <= cmd_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("queue count out of range");
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'd2 |-> !req.ready) else $error("accept while full");
   a_count_move: assert property (@(posedge clock) disable iff (reset)
      (push && !cmd_take) |=> count_ff != 2'd0) else $error("lost entry");
endmodule
`default_nettype wire

// ===== src/tsg3_execute.sv =====
// Back end: turtle state, rotation datapath, stack memory and result register.
`default_nettype none
module tsg3_execute (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire tsg3_pkg::cmd_type cmd,
   input  wire logic              cmd_valid,
   output logic                   cmd_take,
   input  wire logic signed [15:0] cos_angle,
   input  wire logic signed [15:0] sin_angle,
   input  wire logic [23:0]       step_length,
   tsg3_rsp_if.source             rsp
);
   localparam int AW = tsg3_pkg::AddrWidth;
   localparam int LW = tsg3_pkg::LevelWidth;

   logic signed [31:0] pos_ff [3];
   logic signed [15:0] mat_ff [9];
   logic [LW-1:0]      level_ff;
   logic               phase_ff;     // 1: commit phase (products registered / pop read)
   logic signed [31:0] prod_ff [12]; // rotation products, or forward deltas in [0..2]
   logic               rsp_valid_ff;
   tsg3_pkg::result_type rsp_ff;

   // stack memory: one row holds position and matrix
   logic [96+144-1:0] stack_mem [tsg3_pkg::StackDepth];
   logic [96+144-1:0] pop_data_ff;

   // effective state after an optional reset to home
   logic signed [31:0] pos_e [3];
   logic signed [15:0] mat_e [9];
   logic [LW-1:0]      level_e;

   // state and result after the command commits
   logic signed [31:0]   pos_in [3];
   logic signed [15:0]   mat_in [9];
   logic [LW-1:0]        level_in;
   tsg3_pkg::result_type rsp_in;
   logic                 rsp_due;

   int unsigned r0, r1;
   logic signed [16:0] s_eff;        // 17 bits: negating -2.0 (the most negative Q14 value) gives +2.0
   logic               out_free;
   logic               overflow, underflow;
   logic [AW-1:0]      wr_addr, rd_addr;

   always_comb begin
      for (int i = 0; i < 3; i++) pos_e[i] = cmd.home ? 32'sd0 : pos_ff[i];
      for (int i = 0; i < 9; i++)
         mat_e[i] = cmd.home ? ((i % 4 == 0) ? tsg3_pkg::OneQ14 : 16'sd0) : mat_ff[i];
      level_e = cmd.home ? '0 : level_ff;
   end

   always_comb begin
      case (cmd.axis)
         tsg3_pkg::AXIS_Z: begin r0 = 0; r1 = 1; end
         tsg3_pkg::AXIS_Y: begin r0 = 2; r1 = 0; end
         tsg3_pkg::AXIS_X: begin r0 = 1; r1 = 2; end
         default:          begin r0 = 0; r1 = 1; end
      endcase
      s_eff = cmd.negate ? -(17'(sin_angle)) : 17'(sin_angle);
   end

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign overflow  = (level_e == LW'(tsg3_pkg::StackDepth));
   assign underflow = (level_e == '0);
   assign wr_addr   = level_e[AW-1:0];
   assign rd_addr   = AW'(level_e - LW'(1));

   // Each command has a first phase that registers the products and a commit phase.
   // Results can only arise in the commit phase, so only it needs out_free.
   assign cmd_take = cmd_valid && phase_ff && out_free;

   always_ff @(posedge clock) begin
      if (reset) phase_ff <= 1'b0;
      else if (cmd_valid && !phase_ff) phase_ff <= 1'b1;
      else if (cmd_take) phase_ff <= 1'b0;
   end

   // first phase: multiplies and stack read
   always_ff @(posedge clock) begin
      if (cmd_valid && !phase_ff) begin
         if (cmd.op == tsg3_pkg::OP_FORWARD) begin
            for (int j = 0; j < 3; j++)
               prod_ff[j] <= 32'(($signed({1'b0, step_length}) * mat_e[3 + j]
                  + 41'sd8192) >>> 14);
         end else begin
            for (int j = 0; j < 3; j++) begin
               prod_ff[j]     <= cos_angle * mat_e[r0*3 + j];
               prod_ff[3 + j] <= s_eff * mat_e[r1*3 + j];
               prod_ff[6 + j] <= -(s_eff * mat_e[r0*3 + j]);
               prod_ff[9 + j] <= cos_angle * mat_e[r1*3 + j];
            end
         end
         pop_data_ff <= stack_mem[rd_addr];
      end
   end

   // commit phase: next state
   always_comb begin
      for (int i = 0; i < 3; i++) pos_in[i] = pos_e[i];
      for (int i = 0; i < 9; i++) mat_in[i] = mat_e[i];
      level_in = level_e;
      case (cmd.op)
         tsg3_pkg::OP_FORWARD:
            for (int j = 0; j < 3; j++)
               pos_in[j] = tsg3_pkg::sat32(33'(pos_e[j]) + 33'(prod_ff[j]));
         tsg3_pkg::OP_ROTATE:
            for (int j = 0; j < 3; j++) begin
               mat_in[r0*3 + j] = tsg3_pkg::sat16(34'((34'(prod_ff[j])
                  + 34'(prod_ff[3 + j]) + 34'sd8192) >>> 14));
               mat_in[r1*3 + j] = tsg3_pkg::sat16(34'((34'(prod_ff[6 + j])
                  + 34'(prod_ff[9 + j]) + 34'sd8192) >>> 14));
            end
         tsg3_pkg::OP_PUSH:
            if (!overflow) level_in = level_e + LW'(1);
         tsg3_pkg::OP_POP:
            if (!underflow) begin
               level_in  = level_e - LW'(1);
               pos_in[0] = pop_data_ff[239:208];
               pos_in[1] = pop_data_ff[207:176];
               pos_in[2] = pop_data_ff[175:144];
               for (int i = 0; i < 9; i++)
                  mat_in[i] = pop_data_ff[143 - 16*i -: 16];
            end
         default: ;
      endcase
   end

   // commit phase: result
   always_comb begin
      rsp_in  = '0;
      rsp_due = 1'b0;
      case (cmd.op)
         tsg3_pkg::OP_FORWARD: begin
            rsp_due        = 1'b1;
            rsp_in.status  = tsg3_pkg::StatusSegment;
            rsp_in.start_x = pos_e[0];
            rsp_in.start_y = pos_e[1];
            rsp_in.start_z = pos_e[2];
            rsp_in.end_x   = pos_in[0];
            rsp_in.end_y   = pos_in[1];
            rsp_in.end_z   = pos_in[2];
         end
         tsg3_pkg::OP_PUSH:
            if (overflow) begin
               rsp_due       = 1'b1;
               rsp_in.status = tsg3_pkg::StatusOverflow;
            end
         tsg3_pkg::OP_POP:
            if (underflow) begin
               rsp_due       = 1'b1;
               rsp_in.status = tsg3_pkg::StatusUnderflow;
            end
         default: ;
      endcase
   end

   // commit phase: stack write
   always_ff @(posedge clock) begin
      if (cmd_take && cmd.op == tsg3_pkg::OP_PUSH && !overflow)
         stack_mem[wr_addr] <= {pos_e[0], pos_e[1], pos_e[2], mat_e[0], mat_e[1],
            mat_e[2], mat_e[3], mat_e[4], mat_e[5], mat_e[6], mat_e[7], mat_e[8]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
         for (int i = 0; i < 3; i++) pos_ff[i] <= '0;
         for (int i = 0; i < 9; i++)
            mat_ff[i] <= (i % 4 == 0) ? tsg3_pkg::OneQ14 : 16'sd0;
      end else if (cmd_take) begin
         for (int i = 0; i < 3; i++) pos_ff[i] <= pos_in[i];
         for (int i = 0; i < 9; i++) mat_ff[i] <= mat_in[i];
         level_ff <= level_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd_take && rsp_due) rsp_valid_ff <= 1'b1;
      else if (rsp.ready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd_take && rsp_due) rsp_ff <= rsp_in;
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.status  = rsp_ff.status;
   assign rsp.start_x = rsp_ff.start_x;
   assign rsp.start_y = rsp_ff.start_y;
   assign rsp.start_z = rsp_ff.start_z;
   assign rsp.end_x   = rsp_ff.end_x;
   assign rsp.end_y   = rsp_ff.end_y;
   assign rsp.end_z   = rsp_ff.end_z;

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LW'(tsg3_pkg::StackDepth)) else $error("stack level overrun");
   a_take_phase: assert property (@(posedge clock) disable iff (reset)
      cmd_take |-> phase_ff) else $error("command taken in first cycle");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp.ready) |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("result overwritten while stalled");
   a_phase_alt: assert property (@(posedge clock) disable iff (reset)
      cmd_take |=> !phase_ff) else $error("phase not restarted");
endmodule
`default_nettype wire
